// ----- hdl/heightmap_region_stats_assert.svh -----
// ----------------------------------------------------------------------------
// heightmap region statistics assertion macros
// concurrent assertion shorthands clocked on clock, reset handled inside
// ----------------------------------------------------------------------------
`ifndef HEIGHTMAP_REGION_STATS_ASSERT_SVH
`define HEIGHTMAP_REGION_STATS_ASSERT_SVH

// property checked outside of reset
`define HRS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// property checked at every edge, reset included
`define HRS_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- hdl/hrs_pkg.sv -----
// ----------------------------------------------------------------------------
// hrs_pkg
// shared constants, opcodes and control structs of the height grid block
// ----------------------------------------------------------------------------
package hrs_pkg;

   localparam int GRID_SIZE_DEF = 256;
   localparam int HEIGHT_W      = 16;
   localparam int COORD_W       = 16;
   localparam int AREA_W        = 16;
   localparam int VOLUME_W      = 32;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // grid memory strobes
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

   // divider status
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   function automatic logic [HEIGHT_W-1:0] min_h(input logic [HEIGHT_W-1:0] a,
                                                 input logic [HEIGHT_W-1:0] b);
      return (a < b) ? a : b;
   endfunction

endpackage

// ----- hdl/heightmap_region_stats.sv -----
// ----------------------------------------------------------------------------
// heightmap_region_stats
// height grid with rectangle min, max, mean, tile count and volume queries
// ----------------------------------------------------------------------------
// A write transaction stores one Q8.8 height at the edge that accepts it and
// returns nothing. A query transaction walks the grid memory through its single
// read port: first each vertex of the clamped rectangle, then the four corners of
// each tile. After the walk, a bit-serial divider of DIV_W = 2*clog2(GRID_SIZE)+19
// bits forms the mean. The volume is then halved and divided by three one byte
// per cycle, in ceil(DIV_W/8) steps. The next transaction is taken in the cycle
// the result is presented. While an earlier result still waits on rsp_stall, a
// finished query holds in its last step. The grid holds no defined value after
// reset, so queries must only cover written vertices.
module heightmap_region_stats #(
   parameter int GRID_SIZE = hrs_pkg::GRID_SIZE_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_opcode,
   input  logic signed [hrs_pkg::COORD_W-1:0] req_corner_a_x,
   input  logic signed [hrs_pkg::COORD_W-1:0] req_corner_a_y,
   input  logic signed [hrs_pkg::COORD_W-1:0] req_corner_b_x,
   input  logic signed [hrs_pkg::COORD_W-1:0] req_corner_b_y,
   input  logic [hrs_pkg::HEIGHT_W-1:0]  req_height_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [hrs_pkg::HEIGHT_W-1:0]  rsp_min_height,
   output logic [hrs_pkg::HEIGHT_W-1:0]  rsp_max_height,
   output logic [hrs_pkg::HEIGHT_W-1:0]  rsp_mean_height,
   output logic [hrs_pkg::AREA_W-1:0]    rsp_flat_area,
   output logic [hrs_pkg::VOLUME_W-1:0]  rsp_volume
);

`include "heightmap_region_stats_assert.svh"

   localparam int HW    = hrs_pkg::HEIGHT_W;
   localparam int DEPTH = GRID_SIZE * GRID_SIZE;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(GRID_SIZE);
   localparam int CNT_W = 2 * CW + 1;
   localparam int SUM_W = CNT_W + HW;
   localparam int DIV_W = 2 * CW + 19;
   localparam int D3_B  = (DIV_W + 7) / 8;
   localparam int D3_W  = 8 * D3_B;
   localparam int D3C_W = $clog2(D3_B + 1);
   localparam int SAT_W = D3_W + 32;
   localparam int EXT_W = hrs_pkg::COORD_W + 1;
   localparam logic signed [EXT_W-1:0] TileMax  = EXT_W'(GRID_SIZE - 2);
   localparam logic signed [EXT_W-1:0] GridSize = EXT_W'(GRID_SIZE);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_VERT   = 8'b0000_0010,
      ST_TILE   = 8'b0000_0100,
      ST_FLUSH  = 8'b0000_1000,
      ST_DIVM   = 8'b0001_0000,
      ST_WAITM  = 8'b0010_0000,
      ST_WAITV  = 8'b0100_0000,
      ST_DONE   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [CW-1:0]    x0_ff, x0_in, x1_ff, x1_in, y0_ff, y0_in, y1_ff, y1_in;
   logic [CW-1:0]    cx_ff, cx_in, cy_ff, cy_in;
   logic [1:0]       k_ff, k_in;
   logic             rd_vld_ff, rd_vld_in;
   logic             rd_tile_ff, rd_tile_in;
   logic [1:0]       rd_k_ff, rd_k_in;
   logic [HW-1:0]    h1_ff, h1_in, h2_ff, h2_in, h3_ff, h3_in;
   logic [HW-1:0]    lo_ff, lo_in, hi_ff, hi_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [DIV_W-1:0] vol6_ff, vol6_in;
   logic [HW-1:0]    mean_ff, mean_in;
   logic [D3_W-1:0]  d3_ff, d3_in;
   logic [1:0]       d3_rem_ff, d3_rem_in;
   logic [D3C_W-1:0] d3_cnt_ff, d3_cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [HW-1:0]    rsp_min_ff, rsp_min_in, rsp_max_ff, rsp_max_in;
   logic [HW-1:0]    rsp_mean_ff, rsp_mean_in;
   logic [hrs_pkg::AREA_W-1:0]   rsp_area_ff, rsp_area_in;
   logic [hrs_pkg::VOLUME_W-1:0] rsp_vol_ff, rsp_vol_in;

   hrs_pkg::mem_ctl_type  mem_ctl;
   hrs_pkg::div_stat_type div_stat;
   logic [AW-1:0]    wr_addr, rd_addr;
   logic [HW-1:0]    rd_data;
   logic [CW-1:0]    rx, ry;
   logic             div_start;
   logic [DIV_W-1:0] div_dividend, div_divisor, div_quo;
   logic             req_take, wr_in_range, rsp_free;
   logic [HW-1:0]    tm, tp1, tp2;
   logic [DIV_W-1:0] tile6;
   logic [2*CW-1:0]  area_full;
   logic [SAT_W-1:0] vol_ext;
   logic [9:0]       d3_val, d3_q3, d3_rv;
   logic [19:0]      d3_prod;
   logic [7:0]       d3_q;

   function automatic logic [CW-1:0] clamp_tile(input logic signed [EXT_W-1:0] v);
      if (v < 0) begin
         return '0;
      end else if (v > TileMax) begin
         return CW'(TileMax);
      end
      return v[CW-1:0];
   endfunction

   function automatic logic signed [EXT_W-1:0] sext(
      input logic signed [hrs_pkg::COORD_W-1:0] v);
      return {v[hrs_pkg::COORD_W-1], v};
   endfunction

   // request handshake and write address check
   assign req_stall   = (state_ff != ST_IDLE);
   assign req_take    = req_valid && !req_stall;
   assign rsp_free    = !rsp_valid_ff || !rsp_stall;
   assign wr_in_range = (sext(req_corner_a_x) >= 0) && (sext(req_corner_a_x) < GridSize)
                     && (sext(req_corner_a_y) >= 0) && (sext(req_corner_a_y) < GridSize);
   assign wr_addr = AW'(req_corner_a_x[CW-1:0]) + AW'(req_corner_a_y[CW-1:0]) * AW'(GRID_SIZE);

   // read address of the current walk position
   assign rx      = (state_ff == ST_TILE) ? cx_ff + CW'(k_ff[0]) : cx_ff;
   assign ry      = (state_ff == ST_TILE) ? cy_ff + CW'(k_ff[1]) : cy_ff;
   assign rd_addr = AW'(rx) + AW'(ry) * AW'(GRID_SIZE);

   assign mem_ctl.wr_en = req_take && (req_opcode == hrs_pkg::OP_WRITE) && wr_in_range;
   assign mem_ctl.rd_en = (state_ff == ST_VERT) || (state_ff == ST_TILE);

   // sixfold tile volume, last corner straight from memory
   assign tm    = hrs_pkg::min_h(h2_ff, h3_ff);
   assign tp1   = hrs_pkg::min_h(tm, h1_ff);
   assign tp2   = hrs_pkg::min_h(tm, rd_data);
   assign tile6 = DIV_W'(tp1) + DIV_W'(tp2) + (DIV_W'(h2_ff) << 1) + (DIV_W'(h3_ff) << 1);

   // mean divider operands
   assign div_start    = (state_ff == ST_DIVM);
   assign div_dividend = DIV_W'(sum_ff);
   assign div_divisor  = DIV_W'(count_ff);

   // volume by six: halved, then divided by three one byte per cycle
   assign d3_val  = {d3_rem_ff, d3_ff[D3_W-1 -: 8]};
   assign d3_prod = 20'(d3_val) * 20'd683;
   assign d3_q    = d3_prod[18:11];
   assign d3_q3   = 10'(d3_q) * 10'd3;
   assign d3_rv   = d3_val - d3_q3;

   assign area_full = (2*CW)'(x1_ff - x0_ff + 1'b1) * (2*CW)'(y1_ff - y0_ff + 1'b1);
   assign vol_ext   = SAT_W'(d3_ff);

   // control and walk
   always_comb begin
      state_in     = state_ff;
      x0_in        = x0_ff;
      x1_in        = x1_ff;
      y0_in        = y0_ff;
      y1_in        = y1_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      k_in         = k_ff;
      rd_vld_in    = mem_ctl.rd_en;
      rd_tile_in   = (state_ff == ST_TILE);
      rd_k_in      = k_ff;
      h1_in        = h1_ff;
      h2_in        = h2_ff;
      h3_in        = h3_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      vol6_in      = vol6_ff;
      mean_in      = mean_ff;
      d3_in        = d3_ff;
      d3_rem_in    = d3_rem_ff;
      d3_cnt_in    = d3_cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_min_in   = rsp_min_ff;
      rsp_max_in   = rsp_max_ff;
      rsp_mean_in  = rsp_mean_ff;
      rsp_area_in  = rsp_area_ff;
      rsp_vol_in   = rsp_vol_ff;

      // fold in the word read last cycle
      if (rd_vld_ff) begin
         if (!rd_tile_ff) begin
            lo_in    = hrs_pkg::min_h(lo_ff, rd_data);
            hi_in    = (rd_data > hi_ff) ? rd_data : hi_ff;
            sum_in   = sum_ff + SUM_W'(rd_data);
            count_in = count_ff + 1'b1;
         end else begin
            case (rd_k_ff)
               2'd0:    h1_in = rd_data;
               2'd1:    h2_in = rd_data;
               2'd2:    h3_in = rd_data;
               default: vol6_in = vol6_ff + tile6;
            endcase
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_opcode == hrs_pkg::OP_QUERY)) begin
               x0_in    = clamp_tile((req_corner_a_x < req_corner_b_x) ?
                                     sext(req_corner_a_x) : sext(req_corner_b_x));
               x1_in    = clamp_tile((req_corner_a_x < req_corner_b_x) ?
                                     sext(req_corner_b_x) : sext(req_corner_a_x));
               y0_in    = clamp_tile((req_corner_a_y < req_corner_b_y) ?
                                     sext(req_corner_a_y) : sext(req_corner_b_y));
               y1_in    = clamp_tile((req_corner_a_y < req_corner_b_y) ?
                                     sext(req_corner_b_y) : sext(req_corner_a_y));
               cx_in    = x0_in;
               cy_in    = y0_in;
               k_in     = 2'd0;
               lo_in    = '1;
               hi_in    = '0;
               sum_in   = '0;
               count_in = '0;
               vol6_in  = '0;
               state_in = ST_VERT;
            end
         end
         ST_VERT: begin
            if (cx_ff == x1_ff + 1'b1) begin
               cx_in = x0_ff;
               if (cy_ff == y1_ff + 1'b1) begin
                  cy_in    = y0_ff;
                  state_in = ST_TILE;
               end else begin
                  cy_in = cy_ff + 1'b1;
               end
            end else begin
               cx_in = cx_ff + 1'b1;
            end
         end
         ST_TILE: begin
            k_in = k_ff + 1'b1;
            if (k_ff == 2'd3) begin
               if (cx_ff == x1_ff) begin
                  cx_in = x0_ff;
                  if (cy_ff == y1_ff) begin
                     state_in = ST_FLUSH;
                  end else begin
                     cy_in = cy_ff + 1'b1;
                  end
               end else begin
                  cx_in = cx_ff + 1'b1;
               end
            end
         end
         ST_FLUSH: begin
            state_in = ST_DIVM;
         end
         ST_DIVM: begin
            state_in = ST_WAITM;
         end
         ST_WAITM: begin
            if (div_stat.done) begin
               mean_in   = div_quo[HW-1:0];
               d3_in     = D3_W'(vol6_ff >> 1);
               d3_rem_in = '0;
               d3_cnt_in = D3C_W'(D3_B);
               state_in  = ST_WAITV;
            end
         end
         ST_WAITV: begin
            if (d3_cnt_ff != '0) begin
               d3_in     = {d3_ff[D3_W-9:0], d3_q};
               d3_rem_in = d3_rv[1:0];
               d3_cnt_in = d3_cnt_ff - 1'b1;
            end else begin
               state_in  = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_min_in   = lo_ff;
               rsp_max_in   = hi_ff;
               rsp_mean_in  = mean_ff;
               rsp_area_in  = hrs_pkg::AREA_W'(area_full);
               rsp_vol_in   = (vol_ext > SAT_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF :
                              vol_ext[hrs_pkg::VOLUME_W-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         k_ff         <= 2'd0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         k_ff         <= k_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      x0_ff       <= x0_in;
      x1_ff       <= x1_in;
      y0_ff       <= y0_in;
      y1_ff       <= y1_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      rd_tile_ff  <= rd_tile_in;
      rd_k_ff     <= rd_k_in;
      h1_ff       <= h1_in;
      h2_ff       <= h2_in;
      h3_ff       <= h3_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      sum_ff      <= sum_in;
      count_ff    <= count_in;
      vol6_ff     <= vol6_in;
      mean_ff     <= mean_in;
      d3_ff       <= d3_in;
      d3_rem_ff   <= d3_rem_in;
      d3_cnt_ff   <= d3_cnt_in;
      rsp_min_ff  <= rsp_min_in;
      rsp_max_ff  <= rsp_max_in;
      rsp_mean_ff <= rsp_mean_in;
      rsp_area_ff <= rsp_area_in;
      rsp_vol_ff  <= rsp_vol_in;
   end

   hrs_grid_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_grid_mem (
      .clock   (clock),
      .ctl     (mem_ctl),
      .wr_addr (wr_addr),
      .wr_data (req_height_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   hrs_div #(
      .W (DIV_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .stat     (div_stat),
      .quotient (div_quo)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_min_height  = rsp_min_ff;
   assign rsp_max_height  = rsp_max_ff;
   assign rsp_mean_height = rsp_mean_ff;
   assign rsp_flat_area   = rsp_area_ff;
   assign rsp_volume      = rsp_vol_ff;

   // checks on walk and divider sequencing
   `HRS_ASSERT(a_rd_follows_walk, rd_vld_ff |-> ($past(state_ff) == ST_VERT || $past(state_ff) == ST_TILE), "read data without a walk cycle")
   `HRS_ASSERT(a_div_start_idle, div_start |-> !div_stat.busy, "divider restarted while busy")
   `HRS_ASSERT(a_vert_bounds, (state_ff == ST_VERT) |-> (cx_ff <= x1_ff + 1'b1 && cy_ff <= y1_ff + 1'b1), "vertex walk out of bounds")
   `HRS_ASSERT(a_corner_idx, (k_ff != 2'd0) |-> (state_ff == ST_TILE), "corner index left set outside tile walk")
   `HRS_ASSERT_ALWAYS(a_no_write_busy, mem_ctl.wr_en |-> !mem_ctl.rd_en, "grid write during walk")

endmodule

// ----- hdl/hrs_grid_mem.sv -----
// ----------------------------------------------------------------------------
// hrs_grid_mem
// height grid storage, one write port and one registered read port
// ----------------------------------------------------------------------------
module hrs_grid_mem #(
   parameter int DEPTH = hrs_pkg::GRID_SIZE_DEF * hrs_pkg::GRID_SIZE_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                          clock,
   input  hrs_pkg::mem_ctl_type          ctl,
   input  logic [AW-1:0]                 wr_addr,
   input  logic [hrs_pkg::HEIGHT_W-1:0]  wr_data,
   input  logic [AW-1:0]                 rd_addr,
   output logic [hrs_pkg::HEIGHT_W-1:0]  rd_data
);

   logic [hrs_pkg::HEIGHT_W-1:0] grid_ff [DEPTH];
   logic [hrs_pkg::HEIGHT_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         grid_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= grid_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/hrs_div.sv -----
// ----------------------------------------------------------------------------
// hrs_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module hrs_div #(
   parameter int W = 36
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [W-1:0]          dividend,
   input  logic [W-1:0]          divisor,
   output hrs_pkg::div_stat_type stat,
   output logic [W-1:0]          quotient
);

   localparam int CNT_W = $clog2(W + 1);

   logic [W-1:0]     rem_ff, rem_in;
   logic [W-1:0]     quo_ff, quo_in;
   logic [W-1:0]     den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [W:0]       trial;
   logic [W:0]       diff;

   // one shift and subtract step
   assign trial = {rem_ff, quo_ff[W-1]};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         den_in = divisor;
         cnt_in = CNT_W'(W);
      end else if (cnt_ff != '0) begin
         if (!diff[W]) begin
            rem_in = diff[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign stat.busy = (cnt_ff != '0);
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule
